@@ hdl/pvm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PCM voice mixer package
// Shared types and request codes for the four-voice PCM sample mixer.
// ----------------------------------------------------------------------------
package pvm_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int GAIN_W    = 8;
    localparam int MUL_A_W   = 10;
    localparam int PAN_CENTER = 128;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]          gain_t;
    typedef logic signed [MUL_A_W-1:0]  mul_a_t;

    typedef enum logic [2:0] {
        REQ_MIX       = 3'd0,
        REQ_WRITE     = 3'd1,
        REQ_START     = 3'd2,
        REQ_STOP_LOOP = 3'd3,
        REQ_VOLUME    = 3'd4,
        REQ_PAN       = 3'd5,
        REQ_PITCH     = 3'd6
    } req_code_t;

endpackage : pvm_pkg
`default_nettype wire

@@ hdl/pvm_sample_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PCM voice mixer sample memory
// Single-port byte memory holding signed PCM samples, with registered read.
// ----------------------------------------------------------------------------
module pvm_sample_ram #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] addr,
    input  wire pvm_pkg::sample_t     wr_data,
    output pvm_pkg::sample_t          rd_data
);
    import pvm_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    sample_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule : pvm_sample_ram
`default_nettype wire

@@ hdl/pvm_scale_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PCM voice mixer scale unit
// Shared signed-by-unsigned multiplier whose registered result is the
// product divided by 256, rounded toward minus infinity, kept to 8 bits.
// ----------------------------------------------------------------------------
module pvm_scale_unit (
    input  wire logic           clk,
    input  wire pvm_pkg::mul_a_t a,
    input  wire pvm_pkg::gain_t  b,
    output pvm_pkg::gain_t       res
);
    import pvm_pkg::*;

    logic signed [MUL_A_W+GAIN_W:0] prod;

    assign prod = a * $signed({1'b0, b});

    always_ff @(posedge clk)
    begin
        res <= prod[GAIN_W+SAMPLE_W-1:GAIN_W];
    end

endmodule : pvm_scale_unit
`default_nettype wire

@@ hdl/pcm_voice_mixer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// PCM voice mixer
// Multi-voice stereo mixer of signed 8-bit PCM samples from an internal
// sample memory, with per-voice looping, volume, panning and 8.8 pitch.
// ----------------------------------------------------------------------------
// Write, stop-loop and pitch requests finish in IDLE; start, volume and pan
// requests also pass GAIN_L, GAIN_R and GAIN_DONE, as the gains go through the
// shared multiplier. A mix tick runs PTR and CHECK per silent voice and PTR,
// CHECK, MUL_L, MUL_R and ACC_R per playing voice, then FINISH posts the result;
// the voices go in turn via the single multiplier and single sample memory port.
// Reset clears all voice state and the output register; sample RAM has no reset.
module pcm_voice_mixer_unit #(
    parameter int VOICES    = 4,
    parameter int ADDR_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic [2:0]        req_type,
    input  wire logic [1:0]        voice,
    input  wire logic [15:0]       start_addr,
    input  wire logic [15:0]       end_addr,
    input  wire logic [15:0]       loop_start_addr,
    input  wire logic [15:0]       loop_end_addr,
    input  wire pvm_pkg::gain_t    gain_volume,
    input  wire pvm_pkg::sample_t  pan,
    input  wire logic [15:0]       step_pitch,
    input  wire pvm_pkg::sample_t  mem_data,
    output logic                   smp_valid,
    input  wire logic              smp_stall,
    output pvm_pkg::sample_t       left_sample,
    output pvm_pkg::sample_t       right_sample
);
    import pvm_pkg::*;

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PTR_W  = ADDR_BITS + 1;
    localparam int POS_W  = ADDR_BITS + 9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_GAIN_DONE,
        ST_PTR,
        ST_CHECK,
        ST_MUL_L,
        ST_MUL_R,
        ST_ACC_R,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [ADDR_BITS-1:0] start_reg      [VOICES];
    logic [ADDR_BITS-1:0] end_reg        [VOICES];
    logic [ADDR_BITS-1:0] loop_start_reg [VOICES];
    logic [ADDR_BITS-1:0] loop_end_reg   [VOICES];
    gain_t                volume_reg     [VOICES];
    sample_t              pan_reg        [VOICES];
    gain_t                gain_l_reg     [VOICES];
    gain_t                gain_r_reg     [VOICES];
    logic                 loop_en_reg    [VOICES];
    logic [15:0]          rate_reg       [VOICES];
    logic [POS_W-1:0]     pos_reg        [VOICES];

    logic [VIDX_W-1:0]    idx_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic [POS_W-1:0]     wpos_reg;
    sample_t              acc_l_reg;
    sample_t              acc_r_reg;
    logic                 smp_valid_reg;
    sample_t              left_reg;
    sample_t              right_reg;

    logic                 accept;
    logic                 voice_ok;
    logic [VIDX_W-1:0]    in_idx;
    logic [PTR_W-1:0]     ptr_sum;
    logic [PTR_W-1:0]     loop_diff;
    logic                 loop_hit;
    logic                 active;
    logic                 last_voice;
    mul_a_t               pan_ext;
    mul_a_t               mul_a;
    gain_t                mul_b;
    gain_t                mul_res;
    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [ADDR_BITS-1:0] ram_addr;
    sample_t              ram_rd_data;

    assign req_stall    = (state_reg != ST_IDLE);
    assign accept       = req_valid && !req_stall;
    assign voice_ok     = (32'(voice) < VOICES);
    assign in_idx       = VIDX_W'(voice);

    assign ptr_sum   = PTR_W'(start_reg[idx_reg]) + pos_reg[idx_reg][POS_W-1:8];
    assign loop_diff = PTR_W'(loop_start_reg[idx_reg]) - PTR_W'(start_reg[idx_reg]);
    assign loop_hit  = loop_en_reg[idx_reg] && (ptr_sum >= PTR_W'(loop_end_reg[idx_reg]));
    assign active    = (ptr_reg < PTR_W'(end_reg[idx_reg]));
    assign last_voice = (idx_reg == VIDX_W'(VOICES - 1));

    assign pan_ext = mul_a_t'(pan_reg[idx_reg]);

    always_comb
    begin
        mul_a = mul_a_t'(ram_rd_data);
        mul_b = gain_l_reg[idx_reg];
        case (state_reg)
            ST_GAIN_L:
            begin
                mul_a = mul_a_t'(PAN_CENTER) - pan_ext;
                mul_b = volume_reg[idx_reg];
            end
            ST_GAIN_R:
            begin
                mul_a = mul_a_t'(PAN_CENTER) + pan_ext;
                mul_b = volume_reg[idx_reg];
            end
            ST_MUL_R:
            begin
                mul_b = gain_r_reg[idx_reg];
            end
            default:
            begin
                mul_b = gain_l_reg[idx_reg];
            end
        endcase
    end

    assign ram_wr_en = accept && (req_type == REQ_WRITE);
    assign ram_rd_en = (state_reg == ST_CHECK) && active;
    assign ram_addr  = (state_reg == ST_IDLE) ? ADDR_BITS'(start_addr)
                                              : ptr_reg[ADDR_BITS-1:0];

    pvm_sample_ram #(
        .ADDR_BITS (ADDR_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .rd_en   (ram_rd_en),
        .addr    (ram_addr),
        .wr_data (mem_data),
        .rd_data (ram_rd_data)
    );

    pvm_scale_unit u_scale (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .res (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            wpos_reg      <= '0;
            acc_l_reg     <= '0;
            acc_r_reg     <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            smp_valid_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                start_reg[i]      <= '0;
                end_reg[i]        <= '0;
                loop_start_reg[i] <= '0;
                loop_end_reg[i]   <= '0;
                volume_reg[i]     <= '0;
                pan_reg[i]        <= '0;
                gain_l_reg[i]     <= '0;
                gain_r_reg[i]     <= '0;
                loop_en_reg[i]    <= 1'b0;
                rate_reg[i]       <= '0;
                pos_reg[i]        <= '0;
            end
        end
        else
        begin
            if (smp_valid_reg && !smp_stall && (state_reg != ST_FINISH))
            begin
                smp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (req_type)
                            REQ_MIX:
                            begin
                                idx_reg   <= '0;
                                acc_l_reg <= '0;
                                acc_r_reg <= '0;
                                state_reg <= ST_PTR;
                            end
                            REQ_START:
                            begin
                                if (voice_ok)
                                begin
                                    idx_reg                <= in_idx;
                                    start_reg[in_idx]      <= ADDR_BITS'(start_addr);
                                    end_reg[in_idx]        <= ADDR_BITS'(end_addr);
                                    loop_start_reg[in_idx] <= ADDR_BITS'(loop_start_addr);
                                    loop_end_reg[in_idx]   <= ADDR_BITS'(loop_end_addr);
                                    volume_reg[in_idx]     <= gain_volume;
                                    pan_reg[in_idx]        <= pan;
                                    loop_en_reg[in_idx]    <= 1'b1;
                                    pos_reg[in_idx]        <= '0;
                                    rate_reg[in_idx]       <= step_pitch;
                                    state_reg              <= ST_GAIN_L;
                                end
                            end
                            REQ_STOP_LOOP:
                            begin
                                if (voice_ok)
                                begin
                                    loop_en_reg[in_idx] <= 1'b0;
                                end
                            end
                            REQ_VOLUME:
                            begin
                                if (voice_ok)
                                begin
                                    idx_reg            <= in_idx;
                                    volume_reg[in_idx] <= gain_volume;
                                    state_reg          <= ST_GAIN_L;
                                end
                            end
                            REQ_PAN:
                            begin
                                if (voice_ok)
                                begin
                                    idx_reg         <= in_idx;
                                    pan_reg[in_idx] <= pan;
                                    state_reg       <= ST_GAIN_L;
                                end
                            end
                            REQ_PITCH:
                            begin
                                if (voice_ok)
                                begin
                                    rate_reg[in_idx] <= step_pitch;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_GAIN_L:
                begin
                    state_reg <= ST_GAIN_R;
                end
                ST_GAIN_R:
                begin
                    gain_l_reg[idx_reg] <= mul_res;
                    state_reg           <= ST_GAIN_DONE;
                end
                ST_GAIN_DONE:
                begin
                    gain_r_reg[idx_reg] <= mul_res;
                    state_reg           <= ST_IDLE;
                end
                ST_PTR:
                begin
                    if (loop_hit)
                    begin
                        wpos_reg <= {loop_diff, 8'd0};
                        ptr_reg  <= PTR_W'(loop_start_reg[idx_reg]);
                    end
                    else
                    begin
                        wpos_reg <= pos_reg[idx_reg];
                        ptr_reg  <= ptr_sum;
                    end
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (active)
                    begin
                        state_reg <= ST_MUL_L;
                    end
                    else
                    begin
                        pos_reg[idx_reg] <= wpos_reg;
                        if (last_voice)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + VIDX_W'(1);
                            state_reg <= ST_PTR;
                        end
                    end
                end
                ST_MUL_L:
                begin
                    state_reg <= ST_MUL_R;
                end
                ST_MUL_R:
                begin
                    acc_l_reg <= acc_l_reg + mul_res;
                    state_reg <= ST_ACC_R;
                end
                ST_ACC_R:
                begin
                    acc_r_reg        <= acc_r_reg + mul_res;
                    pos_reg[idx_reg] <= wpos_reg + POS_W'(rate_reg[idx_reg]);
                    if (last_voice)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + VIDX_W'(1);
                        state_reg <= ST_PTR;
                    end
                end
                ST_FINISH:
                begin
                    if (!smp_valid_reg || !smp_stall)
                    begin
                        left_reg      <= acc_l_reg;
                        right_reg     <= acc_r_reg;
                        smp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign smp_valid    = smp_valid_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;

endmodule : pcm_voice_mixer_unit
`default_nettype wire
